[rtl/sds_pkg.sv]
// Shared constants for the SCAN disk scheduler: default sizes and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package sds_pkg;

	// Default sizes handed to the top level parameters
	localparam int MAX_REQUESTS_DEF  = 32;
	localparam int CYLINDER_BITS_DEF = 16;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISK_SIZE  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_HEAD = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SWEEP_UP   = 2'd2;

endpackage

[rtl/sds_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port; read data holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/scan_disk_scheduler_top.sv]
// SCAN (elevator) disk scheduler top level.
// Depends on sds_pkg and sds_ram.
`timescale 1ns / 1ps

// The block takes one job of cylinder requests, one word per cycle, and
// keeps up to MAX_REQUESTS of them in a request RAM (more are dropped; the
// last marker still starts the job). When the word with last_request
// arrives, the block stops taking input, sorts the RAM in place with an
// insertion sort through its single read port, finds the first request above
// start_head, and then walks the SCAN order: one result word per request plus
// one for the disk edge, each with the saturating running head movement.
// The sort reads and shifts the entries one at a time through the request
// RAM's single read port, the split search reads the sorted entries in order
// until one lies above start_head, and each result waits while the output
// word register is full and out_ready is low. Configuration (disk_size,
// start_head, sweep_up) is sampled while a job is scheduled and must only be
// written between jobs. The output word sits in its own register, so the next
// job starts loading while the final result waits to be taken.

module scan_disk_scheduler_top #(
	parameter int MAX_REQUESTS  = sds_pkg::MAX_REQUESTS_DEF,
	parameter int CYLINDER_BITS = sds_pkg::CYLINDER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CYLINDER_BITS:0]            cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [CYLINDER_BITS-1:0]          cylinder,
	input  logic                              last_request,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [CYLINDER_BITS-1:0]          position,
	output logic [CYLINDER_BITS:0]            total_moved,
	output logic                              at_edge,
	output logic                              last_result
);

	localparam int CB    = CYLINDER_BITS;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W = $clog2(MAX_REQUESTS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
	localparam logic [CB:0]      SIZE_FULL = (CB+1)'(1) << CB;

	// sequencer codes
	localparam logic [3:0] ST_LOAD      = 4'd0;
	localparam logic [3:0] ST_SORT_I    = 4'd1;
	localparam logic [3:0] ST_SORT_V    = 4'd2;
	localparam logic [3:0] ST_SORT_CMP  = 4'd3;
	localparam logic [3:0] ST_SORT_PUT  = 4'd4;
	localparam logic [3:0] ST_SPLIT_RD  = 4'd5;
	localparam logic [3:0] ST_SPLIT_CMP = 4'd6;
	localparam logic [3:0] ST_RUN_FETCH = 4'd7;
	localparam logic [3:0] ST_RUN_VISIT = 4'd8;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [CB-1:0]    v_q;
	logic [CNT_W-1:0] split_q;
	logic [CNT_W-1:0] p_q;
	logic             leg_q;
	logic             edge_sel_q;
	logic             last_sel_q;
	logic [CB-1:0]    head_q;
	logic [CB:0]      total_q;

	logic [CB:0]      disk_size_q;
	logic [CB-1:0]    start_head_q;
	logic             sweep_up_q;

	logic             out_valid_q;
	logic [CB-1:0]    position_q;
	logic [CB:0]      total_moved_q;
	logic             at_edge_q;
	logic             last_result_q;

	// RAM port
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [CB-1:0]    ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [CB-1:0]    ram_rdata;

	// walk and visit datapath
	logic             ascending;
	logic             leg_more;
	logic [CNT_W-1:0] fetch_idx;
	logic [CB:0]      size_m1;
	logic [CB-1:0]    top_pos;
	logic [CB-1:0]    edge_pos;
	logic [CB-1:0]    visit_pos;
	logic [CB-1:0]    step_dist;
	logic [CB+1:0]    sum;
	logic [CB:0]      total_next;
	logic             slot_free;
	logic             visit_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_LOAD);

	assign out_valid   = out_valid_q;
	assign position    = position_q;
	assign total_moved = total_moved_q;
	assign at_edge     = at_edge_q;
	assign last_result = last_result_q;

	sds_ram #(
		.WIDTH(CB),
		.DEPTH(MAX_REQUESTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q  <= SIZE_FULL;
			start_head_q <= '0;
			sweep_up_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sds_pkg::REG_DISK_SIZE:  disk_size_q  <= cfg_data;
				sds_pkg::REG_START_HEAD: start_head_q <= cfg_data[CB-1:0];
				sds_pkg::REG_SWEEP_UP:   sweep_up_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// leg direction: first leg follows sweep_up, second leg runs the other way
	assign ascending = leg_q ? ~sweep_up_q : sweep_up_q;
	assign leg_more  = ascending ? (p_q < count_q) : (p_q != '0);
	assign fetch_idx = ascending ? p_q : p_q - CNT_W'(1);

	// disk edge with zero and oversize clamping
	assign size_m1 = disk_size_q - (CB+1)'(1);
	always_comb begin
		if (disk_size_q == '0) begin
			top_pos = '0;
		end else if (disk_size_q > SIZE_FULL) begin
			top_pos = '1;
		end else begin
			top_pos = size_m1[CB-1:0];
		end
	end
	assign edge_pos = sweep_up_q ? top_pos : '0;

	// shared visit unit: absolute distance and saturating accumulate
	assign visit_pos  = edge_sel_q ? edge_pos : ram_rdata;
	assign step_dist  = (head_q > visit_pos) ? head_q - visit_pos : visit_pos - head_q;
	assign sum        = {1'b0, total_q} + (CB+2)'(step_dist);
	assign total_next = sum[CB+1] ? '1 : sum[CB:0];

	assign slot_free = ~out_valid_q | out_ready;
	assign visit_go  = (state_q == ST_RUN_VISIT) && slot_free;

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = cylinder;
		ram_re    = 1'b0;
		ram_raddr = fetch_idx[IDX_W-1:0];
		unique case (state_q)
			ST_LOAD: begin
				ram_we = in_valid && (count_q < CNT_MAX);
			end
			ST_SORT_I: begin
				ram_re    = (i_q < count_q);
				ram_raddr = i_q[IDX_W-1:0];
			end
			ST_SORT_V: begin
				ram_re    = 1'b1;
				ram_raddr = j_q - IDX_W'(1);
			end
			ST_SORT_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				if (ram_rdata > v_q) begin
					ram_wdata = ram_rdata;
					ram_re    = (j_q != IDX_W'(1));
					ram_raddr = j_q - IDX_W'(2);
				end else begin
					ram_wdata = v_q;
				end
			end
			ST_SORT_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = v_q;
			end
			ST_SPLIT_RD: begin
				ram_re    = (p_q < count_q);
				ram_raddr = p_q[IDX_W-1:0];
			end
			ST_RUN_FETCH: begin
				ram_re = leg_more;
			end
			default: ;
		endcase
	end

	// sequencer: load, sort, split search, SCAN walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			v_q        <= '0;
			split_q    <= '0;
			p_q        <= '0;
			leg_q      <= 1'b0;
			edge_sel_q <= 1'b0;
			last_sel_q <= 1'b0;
			head_q     <= '0;
			total_q    <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (count_q < CNT_MAX) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_request) begin
							i_q     <= CNT_W'(1);
							state_q <= ST_SORT_I;
						end
					end
				end
				ST_SORT_I: begin
					if (i_q < count_q) begin
						j_q     <= i_q[IDX_W-1:0];
						state_q <= ST_SORT_V;
					end else begin
						p_q     <= '0;
						head_q  <= start_head_q;
						total_q <= '0;
						state_q <= ST_SPLIT_RD;
					end
				end
				ST_SORT_V: begin
					v_q     <= ram_rdata;
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (ram_rdata > v_q) begin
						j_q <= j_q - IDX_W'(1);
						if (j_q == IDX_W'(1)) begin
							state_q <= ST_SORT_PUT;
						end
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_SORT_I;
					end
				end
				ST_SORT_PUT: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_SORT_I;
				end
				ST_SPLIT_RD: begin
					if (p_q < count_q) begin
						state_q <= ST_SPLIT_CMP;
					end else begin
						split_q <= count_q;
						leg_q   <= 1'b0;
						state_q <= ST_RUN_FETCH;
					end
				end
				ST_SPLIT_CMP: begin
					if (head_q < ram_rdata) begin
						split_q <= p_q;
						leg_q   <= 1'b0;
						state_q <= ST_RUN_FETCH;
					end else begin
						p_q     <= p_q + CNT_W'(1);
						state_q <= ST_SPLIT_RD;
					end
				end
				ST_RUN_FETCH: begin
					if (leg_more) begin
						edge_sel_q <= 1'b0;
						p_q        <= ascending ? p_q + CNT_W'(1) : p_q - CNT_W'(1);
						last_sel_q <= leg_q && (ascending ? (p_q + CNT_W'(1) == count_q)
						                                  : (p_q == CNT_W'(1)));
					end else begin
						// first leg done: visit the edge, second leg starts at split
						edge_sel_q <= 1'b1;
						leg_q      <= 1'b1;
						p_q        <= split_q;
						last_sel_q <= sweep_up_q ? (split_q == '0) : (split_q == count_q);
					end
					state_q <= ST_RUN_VISIT;
				end
				ST_RUN_VISIT: begin
					if (slot_free) begin
						head_q  <= visit_pos;
						total_q <= total_next;
						if (last_sel_q) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_RUN_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (visit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (visit_go) begin
			position_q    <= visit_pos;
			total_moved_q <= total_next;
			at_edge_q     <= edge_sel_q;
			last_result_q <= last_sel_q;
		end
	end

endmodule

[dv/tb_scan_disk_scheduler_top.sv]
// Self-checking testbench for scan_disk_scheduler_top: directed jobs from a stimulus table,
// then random jobs under random stalls, all checked against a SCAN schedule predictor.
// Depends on sds_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_scan_disk_scheduler_top;

	localparam int CYL_W       = sds_pkg::CYLINDER_BITS_DEF;
	localparam int MAXQ        = sds_pkg::MAX_REQUESTS_DEF;
	localparam int CYL_TOP     = (1 << CYL_W) - 1;
	localparam int MOVED_SAT   = (1 << (CYL_W + 1)) - 1;
	localparam int STALL_LIMIT = 20000;
	localparam int RAND_WORDS  = 320;
	localparam int SETTLE      = 8;
	localparam int TAIL        = 60;
	// index with no register behind it; writes there must be harmless
	localparam logic [sds_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	// one expected result word
	typedef struct packed {
		logic [CYL_W-1:0] pos;
		logic [CYL_W:0]   moved;
		logic             at_edge;
		logic             fin;
	} visit_t;

	// one directed row: optional config, a request word sent rep times, optional typed result
	typedef struct packed {
		logic             cfg;
		logic [CYL_W:0]   dsize;
		logic [CYL_W-1:0] head;
		logic             up;
		logic [CYL_W-1:0] cyl;
		logic             lst;
		logic [5:0]       rep;
		logic             typed;
		logic [CYL_W-1:0] tpos;
		logic [CYL_W:0]   tmoved;
		logic             tedge;
	} stim_row_t;

	localparam int DIR_ROWS = 18;
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		// after reset: one request at the top cylinder
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd65535, 1'b1, 6'd1, 1'b1, 16'd65535, 17'd65535, 1'b1},
		// one-cylinder disk, head at the top, nothing above it: movement saturates
		'{1'b1, 17'd1, 16'd65535, 1'b1, 16'd0, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd65535, 1'b1, 6'd1, 1'b1, 16'd0, 17'd131071, 1'b0},
		// zero disk size, downward, request equal to head
		'{1'b1, 17'd0, 16'd0, 1'b0, 16'd0, 1'b1, 6'd1, 1'b1, 16'd0, 17'd0, 1'b1},
		// oversized disk gets clamped, upward
		'{1'b1, 17'd131071, 16'd32768, 1'b1, 16'd100, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd40000, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd32768, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd65535, 1'b1, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		// full disk, downward from the middle
		'{1'b1, 17'd65536, 16'd1000, 1'b0, 16'd5000, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd10, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd1000, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd2000, 1'b1, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		// store overflow: 33 requests, then a last request that is dropped too but still ends the job
		'{1'b1, 17'd16, 16'd8, 1'b1, 16'd7, 1'b0, 6'd33, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd3, 1'b1, 6'd1, 1'b1, 16'd7, 17'd15, 1'b0},
		// head and a request beyond the edge of a small disk, downward
		'{1'b1, 17'd16, 16'd20, 1'b0, 16'd40000, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd3, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd20, 1'b0, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0},
		'{1'b0, 17'd0, 16'd0, 1'b0, 16'd15, 1'b1, 6'd1, 1'b0, 16'd0, 17'd0, 1'b0}
	};

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [sds_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [CYL_W:0]                     cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic [CYL_W-1:0]                   cylinder;
	logic                               last_request;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [CYL_W-1:0]                   position;
	logic [CYL_W:0]                     total_moved;
	logic                               at_edge;
	logic                               last_result;

	// predictor state and its copy of the registers
	logic [CYL_W:0]   disk_cyls;
	logic [CYL_W-1:0] head_start;
	logic             sweep_hi;
	int               pend [MAXQ];
	int               pend_n;
	int               head_at;
	int               moved_sum;
	visit_t           visit_q [$];

	bit failed;
	bit quiet;
	int rand_words;
	int stuck_cycles;
	int stall_left;

	scan_disk_scheduler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cylinder     (cylinder),
		.last_request (last_request),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.total_moved  (total_moved),
		.at_edge      (at_edge),
		.last_result  (last_result)
	);

	always #5 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// top edge for a disk size, with zero and oversize handled
	function automatic int top_cyl(logic [CYL_W:0] size);
		if (size == 0)
			return 0;
		if (size > CYL_TOP + 1)
			return CYL_TOP;
		return size - 1;
	endfunction

	// move the head, accumulate saturating movement, queue the word
	function automatic void log_visit(int pos, bit edge_hit);
		visit_t v;
		int d;
		d = (head_at > pos) ? head_at - pos : pos - head_at;
		moved_sum += d;
		if (moved_sum > MOVED_SAT)
			moved_sum = MOVED_SAT;
		head_at = pos;
		v.pos = pos[CYL_W-1:0];
		v.moved = moved_sum[CYL_W:0];
		v.at_edge = edge_hit;
		v.fin = 1'b0;
		visit_q.push_back(v);
	endfunction

	// store one request; on the last one, sort and queue the SCAN order
	function automatic void scan_predict(logic [CYL_W-1:0] cyl, logic lst);
		int srt [MAXQ];
		int n, split, top, i, j, v;
		visit_t tail;
		if (pend_n < MAXQ) begin
			pend[pend_n] = int'(cyl);
			pend_n++;
		end
		if (!lst)
			return;
		n = pend_n;
		for (i = 0; i < n; i++)
			srt[i] = pend[i];
		for (i = 1; i < n; i++) begin
			v = srt[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		top = top_cyl(disk_cyls);
		head_at = int'(head_start);
		moved_sum = 0;
		// first request strictly above the head; none means all count as lower
		split = n;
		for (i = 0; i < n; i++)
			if (split == n && head_at < srt[i])
				split = i;
		if (sweep_hi) begin
			for (i = split; i < n; i++)
				log_visit(srt[i], 1'b0);
			log_visit(top, 1'b1);
			for (i = split; i > 0; i--)
				log_visit(srt[i-1], 1'b0);
		end else begin
			for (i = split; i > 0; i--)
				log_visit(srt[i-1], 1'b0);
			log_visit(0, 1'b1);
			for (i = split; i < n; i++)
				log_visit(srt[i], 1'b0);
		end
		tail = visit_q.pop_back();
		tail.fin = 1'b1;
		visit_q.push_back(tail);
		pend_n = 0;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// one config word; predictor copy follows on acceptance
	task automatic write_reg(logic [sds_pkg::CFG_INDEX_BITS-1:0] idx, logic [CYL_W:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			sds_pkg::REG_DISK_SIZE:  disk_cyls = val;
			sds_pkg::REG_START_HEAD: head_start = val[CYL_W-1:0];
			sds_pkg::REG_SWEEP_UP:   sweep_hi = val[0];
			default: ;
		endcase
	endtask

	// all registers, with junk in the unused upper data bits
	task automatic set_config(logic [CYL_W:0] dsize, logic [CYL_W-1:0] head, logic up);
		write_reg(sds_pkg::REG_DISK_SIZE, dsize);
		write_reg(sds_pkg::REG_START_HEAD, {1'($urandom()), head});
		write_reg(sds_pkg::REG_SWEEP_UP, {16'($urandom()), up});
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, 17'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// one request word, after a random gap
	task automatic send_word(logic [CYL_W-1:0] cyl, logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cylinder <= cyl;
		last_request <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		scan_predict(cyl, lst);
	endtask

	// wait out every pending result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (visit_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// random job: mostly short, a few long, rarely overflowing the store
	task automatic random_job();
		int len, r, lo, hi, k, top;
		logic [CYL_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(1, 6);
		else if (r < 90)
			len = $urandom_range(7, 20);
		else if (r < 97)
			len = $urandom_range(21, 32);
		else
			len = $urandom_range(MAXQ + 1, MAXQ + 8);
		top = top_cyl(disk_cyls);
		case ($urandom_range(0, 2))
			0: begin
				lo = 0;
				hi = CYL_TOP;
			end
			1: begin
				lo = 0;
				hi = top;
			end
			default: begin
				lo = (head_start >= 64) ? head_start - 64 : 0;
				hi = (head_start + 64 > CYL_TOP) ? CYL_TOP : head_start + 64;
			end
		endcase
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: c = '0;
					1: c = CYL_W'(CYL_TOP);
					2: c = head_start;
					default: c = CYL_W'(top);
				endcase
			end else begin
				c = CYL_W'($urandom_range(lo, hi));
			end
			send_word(c, k == len - 1);
			rand_words++;
		end
	endtask

	// result side: random stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// result checker
	always @(posedge clk) begin
		visit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (visit_q.size() == 0) begin
				$error("unexpected result word: position %0d total_moved %0d",
					position, total_moved);
				failed = 1'b1;
			end else begin
				want = visit_q.pop_front();
				check_field("position", int'(want.pos), int'(position));
				check_field("total_moved", int'(want.moved), int'(total_moved));
				check_field("at_edge", int'(want.at_edge), int'(at_edge));
				check_field("last_result", int'(want.fin), int'(last_result));
			end
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		visit_t v;
		logic [CYL_W:0] ds;
		logic [CYL_W-1:0] hd;
		int i, k, top, jobs;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cylinder <= '0;
		last_request <= 1'b0;
		failed = 1'b0;
		quiet = 1'b0;
		stall_left = 0;
		stuck_cycles = 0;
		rand_words = 0;
		disk_cyls = (CYL_W+1)'(CYL_TOP + 1);
		head_start = '0;
		sweep_hi = 1'b1;
		pend_n = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TAB[i];
			if (row.cfg) begin
				drain();
				set_config(row.dsize, row.head, row.up);
			end
			for (k = 0; k < row.rep; k++)
				send_word(row.cyl, row.lst);
			if (row.typed) begin
				v = visit_q.pop_back();
				v.pos = row.tpos;
				v.moved = row.tmoved;
				v.at_edge = row.tedge;
				visit_q.push_back(v);
			end
		end

		// random phases: new settings, then a few jobs back to back
		while (rand_words < RAND_WORDS) begin
			drain();
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 7))
				0: ds = '0;
				1: ds = (CYL_W+1)'(1);
				2: ds = (CYL_W+1)'(CYL_TOP + 1);
				3: ds = (CYL_W+1)'($urandom_range(CYL_TOP + 2, 2 * CYL_TOP + 1));
				4: ds = (CYL_W+1)'($urandom_range(2, 64));
				default: ds = (CYL_W+1)'($urandom_range(1, CYL_TOP + 1));
			endcase
			top = top_cyl(ds);
			case ($urandom_range(0, 5))
				0: hd = '0;
				1: hd = CYL_W'(CYL_TOP);
				2, 3: hd = CYL_W'($urandom_range(0, top));
				default: hd = CYL_W'($urandom_range(0, CYL_TOP));
			endcase
			set_config(ds, hd, 1'($urandom_range(0, 1)));
			jobs = $urandom_range(1, 4);
			repeat (jobs) random_job();
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (failed || visit_q.size() != 0)
			$display("simulation failed");
		else
			$display("simulation ok");
		$finish;
	end

endmodule
